>>> hdl/pis_pkg.sv
// ----------------------------------------------------------------------------
// pis_pkg
// Types and constants shared by the permuted index sort block: beat
// layouts, action codes, controller states and controller/datapath links.
// ----------------------------------------------------------------------------
package pis_pkg;

   // width of every table entry, row index and key
   localparam int FIELD_W = 10;

   // action codes of a request beat
   localparam logic [1:0] ACT_WR_INV = 2'd0;
   localparam logic [1:0] ACT_WR_FWD = 2'd1;
   localparam logic [1:0] ACT_PUSH   = 2'd2;

   typedef logic [FIELD_W-1:0] field_type;

   typedef struct packed {
      logic [1:0] action;
      field_type  table_index;
      field_type  value;
      logic       last_entry;
   } req_type;

   typedef struct packed {
      field_type row_index;
      logic      last_of_run;
      logic      overflow;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_EMIT
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic wr_inv;
      logic wr_fwd;
      logic push;
      logic pop;
      logic pop_last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic one_left;
   } status_type;

endpackage

>>> hdl/pis_cell_chain.sv
// ----------------------------------------------------------------------------
// pis_cell_chain
// Row of sorting cells holding keys in ascending order. A new key is placed
// behind all cells with a key not greater than it; a pop shifts towards the
// head. Cells fill from the head, so valid bits form a prefix.
// ----------------------------------------------------------------------------
module pis_cell_chain #(
   parameter int DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               insert,
   input  pis_pkg::field_type insert_key,
   input  logic               pop,
   output pis_pkg::field_type head_key,
   output logic               one_left,
   output logic               full
);

   pis_pkg::field_type key_ff [DEPTH];
   pis_pkg::field_type key_in [DEPTH];
   logic [DEPTH-1:0]   valid_ff;
   logic [DEPTH-1:0]   valid_in;
   logic [DEPTH-1:0]   ins;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      pis_pkg::field_type ins_key;
      pis_pkg::field_type pop_key;
      logic               ins_valid;
      logic               pop_valid;

      // insertion region: empty cells and cells holding a greater key
      assign ins[g] = !valid_ff[g] || (key_ff[g] > insert_key);

      // take the new key at the region edge, the left neighbour inside it
      if (g == 0) begin : g_head
         assign ins_key   = insert_key;
         assign ins_valid = 1'b1;
      end else begin : g_body
         assign ins_key   = ins[g-1] ? key_ff[g-1] : insert_key;
         assign ins_valid = valid_ff[g] || valid_ff[g-1];
      end

      // shift towards the head on a pop
      if (g == DEPTH-1) begin : g_tail
         assign pop_key   = key_ff[g];
         assign pop_valid = 1'b0;
      end else begin : g_inner
         assign pop_key   = key_ff[g+1];
         assign pop_valid = valid_ff[g+1];
      end

      always_comb begin
         key_in[g]   = key_ff[g];
         valid_in[g] = valid_ff[g];
         if (insert) begin
            if (ins[g]) begin
               key_in[g] = ins_key;
            end
            valid_in[g] = ins_valid;
         end else if (pop) begin
            key_in[g]   = pop_key;
            valid_in[g] = pop_valid;
         end
      end
   end

   // hold cell valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // hold cell keys
   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         key_ff[i] <= key_in[i];
      end
   end

   assign head_key = key_ff[0];
   assign one_left = !valid_ff[1];
   assign full     = valid_ff[DEPTH-1];

endmodule

>>> hdl/pis_datapath.sv
// ----------------------------------------------------------------------------
// pis_datapath
// Both permutation tables, the key lookup stage, the sorting cells and the
// result register. Acts only on commands from the controller.
// ----------------------------------------------------------------------------
module pis_datapath #(
   parameter int MAX_ROWS    = 1024,
   parameter int MAX_PATTERN = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  pis_pkg::cmd_type    cmd,
   input  pis_pkg::req_type    req_data,
   output pis_pkg::status_type status,
   output logic                rsp_valid,
   output pis_pkg::rsp_type    rsp_data
);

   localparam int          ROW_AW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam logic [16:0] ROW_LIMIT = 17'(MAX_ROWS);

   pis_pkg::field_type inv_mem [MAX_ROWS];
   pis_pkg::field_type fwd_mem [MAX_ROWS];

   logic               wr_in_range;
   logic               push_in_range;
   logic               key_in_range;
   logic [ROW_AW-1:0]  wr_addr;
   logic [ROW_AW-1:0]  push_addr;
   logic [ROW_AW-1:0]  key_addr;

   logic               ins_valid_ff;
   logic               ins_oob_ff;
   pis_pkg::field_type inv_q_ff;
   pis_pkg::field_type ins_key;

   logic               overflow_ff;
   logic               chain_full;
   pis_pkg::field_type head_key;

   logic               rsp_valid_ff;
   logic               rsp_oob_ff;
   logic               rsp_last_ff;
   logic               rsp_ovf_ff;
   pis_pkg::field_type fwd_q_ff;

   // positions beyond the table depth are ignored on write and read as zero
   assign wr_in_range   = {7'd0, req_data.table_index} < ROW_LIMIT;
   assign push_in_range = {7'd0, req_data.value} < ROW_LIMIT;
   assign key_in_range  = {7'd0, head_key} < ROW_LIMIT;
   assign wr_addr       = ROW_AW'(req_data.table_index);
   assign push_addr     = ROW_AW'(req_data.value);
   assign key_addr      = ROW_AW'(head_key);

   // inverse table: write port and push lookup
   always_ff @(posedge clock) begin
      if (cmd.wr_inv && wr_in_range) begin
         inv_mem[wr_addr] <= req_data.value;
      end
      if (cmd.push) begin
         inv_q_ff <= inv_mem[push_addr];
      end
   end

   // forward table: write port and emission lookup
   always_ff @(posedge clock) begin
      if (cmd.wr_fwd && wr_in_range) begin
         fwd_mem[wr_addr] <= req_data.value;
      end
      if (cmd.pop) begin
         fwd_q_ff <= fwd_mem[key_addr];
      end
   end

   // advance the pending insert and the result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         ins_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         overflow_ff  <= 1'b0;
      end else begin
         ins_valid_ff <= cmd.push;
         rsp_valid_ff <= cmd.pop;
         if (cmd.pop_last) begin
            overflow_ff <= 1'b0;
         end else if (ins_valid_ff && chain_full) begin
            overflow_ff <= 1'b1;
         end
      end
   end

   // capture side flags with each lookup
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         ins_oob_ff <= !push_in_range;
      end
      if (cmd.pop) begin
         rsp_oob_ff  <= !key_in_range;
         rsp_last_ff <= cmd.pop_last;
         rsp_ovf_ff  <= overflow_ff;
      end
   end

   assign ins_key = ins_oob_ff ? '0 : inv_q_ff;

   // drop the key when every cell is taken
   pis_cell_chain #(
      .DEPTH (MAX_PATTERN)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .insert     (ins_valid_ff && !chain_full),
      .insert_key (ins_key),
      .pop        (cmd.pop),
      .head_key   (head_key),
      .one_left   (status.one_left),
      .full       (chain_full)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_data.row_index   = rsp_oob_ff ? '0 : fwd_q_ff;
   assign rsp_data.last_of_run = rsp_last_ff;
   assign rsp_data.overflow    = rsp_ovf_ff;

endmodule

>>> hdl/pis_ctrl.sv
// ----------------------------------------------------------------------------
// pis_ctrl
// Sequencer: takes request beats while idle, lets the last key settle into
// the cells, then pops one key per cycle until the run is emptied.
// ----------------------------------------------------------------------------
module pis_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          action,
   input  logic                last_entry,
   input  pis_pkg::status_type status,
   output logic                busy,
   output pis_pkg::cmd_type    cmd
);

   pis_pkg::ctrl_state_type state_ff;
   pis_pkg::ctrl_state_type state_in;
   logic                    accept;

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pis_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign accept = start && (state_ff == pis_pkg::ST_IDLE);

   // decode beats and step the sequence
   always_comb begin
      state_in     = state_ff;
      busy         = 1'b1;
      cmd          = '0;
      cmd.wr_inv   = accept && (action == pis_pkg::ACT_WR_INV);
      cmd.wr_fwd   = accept && (action == pis_pkg::ACT_WR_FWD);
      cmd.push     = accept && (action == pis_pkg::ACT_PUSH);
      unique case (state_ff)
         pis_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (cmd.push && last_entry) begin
               state_in = pis_pkg::ST_DRAIN;
            end
         end
         pis_pkg::ST_DRAIN: begin
            state_in = pis_pkg::ST_EMIT;
         end
         pis_pkg::ST_EMIT: begin
            cmd.pop      = 1'b1;
            cmd.pop_last = status.one_left;
            if (status.one_left) begin
               state_in = pis_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pis_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> hdl/permuted_index_sort.sv
// ----------------------------------------------------------------------------
// permuted_index_sort
// Sorts a run of row indices by their key in the inverse permutation and
// returns them mapped through the forward permutation, in ascending order.
//
//   channel   ports                      handshake
//   request   req_data                   taken when start and not busy
//   result    rsp_data                   presented with rsp_valid
//
// Table writes and non-final pushes may follow back to back. A push ending
// a run holds busy while the last key settles in the cells and then while
// the run is popped, one pop per cycle; each result follows its pop in the
// next cycle, registered by the forward table read.
// Reset clears the cells and control only; table contents stay undefined.
// Results are never stalled.
// ----------------------------------------------------------------------------
module permuted_index_sort #(
   parameter int MAX_ROWS    = 1024,
   parameter int MAX_PATTERN = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  pis_pkg::req_type req_data,
   output logic             busy,
   output logic             rsp_valid,
   output pis_pkg::rsp_type rsp_data
);

   pis_pkg::cmd_type    cmd;
   pis_pkg::status_type status;

   pis_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .action     (req_data.action),
      .last_entry (req_data.last_entry),
      .status     (status),
      .busy       (busy),
      .cmd        (cmd)
   );

   pis_datapath #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_PATTERN (MAX_PATTERN)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // results only follow a cycle of emission
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result beat without emission");

   // the final result of a run frees the request side
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last_of_run) |-> !busy)
      else $error("busy after final result");

   // a final push starts the sort
   a_last_push_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.action == pis_pkg::ACT_PUSH) && req_data.last_entry)
      |=> busy)
      else $error("final push did not start sort");
`endif

endmodule
